/* rtl/average_true_range_filter_unit_macros.svh */
// assertion macros for the average true range filter
// clocked on clk_i, disabled while rst_ni is low
`ifndef AVERAGE_TRUE_RANGE_FILTER_UNIT_MACROS_SVH
`define AVERAGE_TRUE_RANGE_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define ATR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/atr_pkg.sv */
// shared types, widths and sequencer codes of the average true range filter
// no dependencies
package atr_pkg;

  localparam int unsigned PRICE_BITS     = 32;
  localparam int unsigned PERIOD_BITS    = 10;
  localparam int unsigned SUM_BITS       = PRICE_BITS + PERIOD_BITS;
  localparam int unsigned INDEX_BITS     = PERIOD_BITS + 1;
  localparam int unsigned ALU_BITS       = SUM_BITS;
  localparam int unsigned CNT_BITS       = $clog2(SUM_BITS);
  localparam int unsigned MUL_STEPS      = PERIOD_BITS;
  localparam int unsigned NUM_CAND       = 4;
  localparam int unsigned PERIOD_MAX_DEF = 1023;
  localparam int unsigned PERIOD_RESET   = 14;

  typedef struct packed {
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;
    logic [PRICE_BITS-1:0] bar_close;
    logic                  series_start;
  } bar_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] range_average;
    logic                  average_ready;
    logic                  series_invalid;
  } atr_result_t;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // what the current bar does to the running average
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ACCUM,
    MODE_SEED,
    MODE_WILDER
  } mode_e;

  typedef logic [3:0] state_t;

  localparam state_t ST_IDLE = 4'd0;
  localparam state_t ST_RNG  = 4'd1;
  localparam state_t ST_CAND = 4'd2;
  localparam state_t ST_CMP  = 4'd3;
  localparam state_t ST_ACC  = 4'd4;
  localparam state_t ST_MUL  = 4'd5;
  localparam state_t ST_MADD = 4'd6;
  localparam state_t ST_DIV  = 4'd7;
  localparam state_t ST_OUT  = 4'd8;

  typedef struct packed {
    state_t              state;
    logic [CNT_BITS-1:0] cnt;
  } atr_ctrl_t;

  typedef struct packed {
    logic  accept;
    logic  no_tr;
    logic  borrow;
    mode_e mode;
    logic  out_free;
  } atr_status_t;

endpackage

/* rtl/atr_alu.sv */
// shared add / subtract unit of the average true range filter
// depends on atr_pkg
module atr_alu (
  input  atr_pkg::alu_op_e              op_i,
  input  logic [atr_pkg::ALU_BITS-1:0]  a_i,
  input  logic [atr_pkg::ALU_BITS-1:0]  b_i,
  output logic [atr_pkg::ALU_BITS-1:0]  res_o,
  output logic                          carry_o
);

  logic [atr_pkg::ALU_BITS:0] full;

  always_comb begin
    unique case (op_i)
      atr_pkg::ALU_ADD: full = {1'b0, a_i} + {1'b0, b_i};
      atr_pkg::ALU_SUB: full = {1'b0, a_i} - {1'b0, b_i};
      default:          full = '0;
    endcase
  end

  // for a subtract the top bit is the borrow
  assign res_o   = full[atr_pkg::ALU_BITS-1:0];
  assign carry_o = full[atr_pkg::ALU_BITS];

endmodule

/* rtl/atr_seq.sv */
// step sequencer of the average true range filter
// depends on atr_pkg
module atr_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atr_pkg::atr_status_t status_i,
  output atr_pkg::atr_ctrl_t   ctrl_o
);

  localparam int unsigned CW = atr_pkg::CNT_BITS;
  localparam logic [CW-1:0] CandLast = CW'(atr_pkg::NUM_CAND - 1);
  localparam logic [CW-1:0] MulLast  = CW'(atr_pkg::MUL_STEPS - 1);
  localparam logic [CW-1:0] DivLast  = CW'(atr_pkg::SUM_BITS - 1);

  atr_pkg::state_t state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      atr_pkg::ST_IDLE: begin
        if (status_i.accept) begin
          state_d = atr_pkg::ST_RNG;
        end
      end
      atr_pkg::ST_RNG: begin
        cnt_d   = '0;
        state_d = status_i.no_tr ? atr_pkg::ST_ACC : atr_pkg::ST_CAND;
      end
      atr_pkg::ST_CAND: begin
        if (status_i.borrow) begin
          // negative difference, skip this candidate
          if (cnt_q == CandLast) begin
            state_d = atr_pkg::ST_ACC;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end else begin
          state_d = atr_pkg::ST_CMP;
        end
      end
      atr_pkg::ST_CMP: begin
        if (cnt_q == CandLast) begin
          state_d = atr_pkg::ST_ACC;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = atr_pkg::ST_CAND;
        end
      end
      atr_pkg::ST_ACC: begin
        cnt_d = '0;
        case (status_i.mode)
          atr_pkg::MODE_SEED:   state_d = atr_pkg::ST_DIV;
          atr_pkg::MODE_WILDER: state_d = atr_pkg::ST_MUL;
          default:              state_d = atr_pkg::ST_OUT;
        endcase
      end
      atr_pkg::ST_MUL: begin
        if (cnt_q == MulLast) begin
          state_d = atr_pkg::ST_MADD;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      atr_pkg::ST_MADD: begin
        cnt_d   = '0;
        state_d = atr_pkg::ST_DIV;
      end
      atr_pkg::ST_DIV: begin
        if (cnt_q == DivLast) begin
          state_d = atr_pkg::ST_OUT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      atr_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          state_d = atr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = atr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atr_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ctrl_o.state = state_q;
  assign ctrl_o.cnt   = cnt_q;

endmodule

/* rtl/average_true_range_filter_unit.sv */
// average true range filter with wilder smoothing, top level; uses atr_pkg, atr_seq, atr_alu
// steps: range, then for bars after the first the candidate and compare steps, then accumulate;
//   the seed bar then divides, smoothing does 10 multiply steps, an add and 42 divide steps,
//   all on one shared adder; the output step waits while a stalled word holds the output register
// throughput: a new bar is taken only when the sequencer is back in idle
// reset: asynchronous, active low; period register goes to 14, running state to zero
`include "average_true_range_filter_unit_macros.svh"

module average_true_range_filter_unit #(
  parameter int unsigned PERIOD_MAX = atr_pkg::PERIOD_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // bar input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  atr_pkg::bar_t                   in_data_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output atr_pkg::atr_result_t            out_data_o,
  // period register
  input  logic                            cfg_we_i,
  input  logic [atr_pkg::PERIOD_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned PB = atr_pkg::PERIOD_BITS;
  localparam int unsigned PW = atr_pkg::PRICE_BITS;
  localparam int unsigned SW = atr_pkg::SUM_BITS;
  localparam int unsigned IW = atr_pkg::INDEX_BITS;
  localparam int unsigned AW = atr_pkg::ALU_BITS;

  // clamp the period maximum to what the register can hold
  localparam int unsigned PeriodLim = (1 << PB) - 1;
  localparam int unsigned PMaxClip  = (PERIOD_MAX > PeriodLim) ? PeriodLim : PERIOD_MAX;
  localparam logic [PB-1:0] PMaxVal = PB'(PMaxClip);

  // sequencer link
  atr_pkg::atr_ctrl_t   ctrl;
  atr_pkg::atr_status_t status;

  // configuration
  logic [PB-1:0] cfg_q;
  logic [PB-1:0] p_eff;

  // running series state
  logic [PW-1:0] last_close_q;
  logic [PW-1:0] smoothed_q;
  logic [SW-1:0] sum_q;
  logic [IW-1:0] bar_index_q;
  logic          invalid_q;

  // per-bar working registers
  atr_pkg::bar_t bar_q;
  logic [PB-1:0] period_q;
  logic [PW-1:0] tr_q;
  logic [PW-1:0] cand_q;
  logic [SW-1:0] work_q;   // product, then dividend shifting into quotient
  logic [SW-1:0] mcand_q;
  logic [PB-1:0] mult_q;
  logic [PB-1:0] rem_q;

  // result register
  logic                 out_valid_q;
  atr_pkg::atr_result_t out_q;

  // shared adder
  atr_pkg::alu_op_e alu_op;
  logic [AW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_carry;

  logic            accept;
  logic            out_free;
  logic            out_load;
  atr_pkg::mode_e  mode;
  logic            ready;
  logic [IW-1:0]   index_cap;
  logic [IW-1:0]   index_next;
  logic [IW-1:0]   rem_shift;
  logic [PW-1:0]   avg;

  assign p_eff = (cfg_q > PMaxVal) ? PMaxVal : cfg_q;

  // block takes a bar only when the sequencer is idle
  assign in_stall_o = (ctrl.state != atr_pkg::ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  // a finished word may wait in the output register while the next bar comes in
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign out_load = (ctrl.state == atr_pkg::ST_OUT) & out_free;

  // role of this bar, from the index already cleared by series start
  always_comb begin
    if ((period_q == '0) || (bar_index_q == '0)) begin
      mode = atr_pkg::MODE_NONE;
    end else if (bar_index_q < IW'(period_q)) begin
      mode = atr_pkg::MODE_ACCUM;
    end else if (bar_index_q == IW'(period_q)) begin
      mode = atr_pkg::MODE_SEED;
    end else begin
      mode = atr_pkg::MODE_WILDER;
    end
  end

  assign ready = (mode == atr_pkg::MODE_SEED) || (mode == atr_pkg::MODE_WILDER);

  // bar index counts up and stops at period plus one
  assign index_cap  = IW'(period_q) + IW'(1);
  assign index_next = (bar_index_q < index_cap) ? (bar_index_q + IW'(1)) : index_cap;

  // restoring divide: partial remainder with the next dividend bit
  assign rem_shift = {rem_q, work_q[SW-1]};

  // average after this bar's update is left in the low bits of the quotient
  assign avg = (ready && !invalid_q) ? work_q[PW-1:0] : '0;

  // operand select for the shared adder
  always_comb begin
    alu_op = atr_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (ctrl.state)
      atr_pkg::ST_RNG: begin
        // high minus low, borrow flags an invalid bar
        alu_op = atr_pkg::ALU_SUB;
        alu_a  = AW'(bar_q.bar_high);
        alu_b  = AW'(bar_q.bar_low);
      end
      atr_pkg::ST_CAND: begin
        // both orders of each gap to the previous close; the one without borrow is the abs
        alu_op = atr_pkg::ALU_SUB;
        case (ctrl.cnt[1:0])
          2'd0: begin
            alu_a = AW'(bar_q.bar_high);
            alu_b = AW'(last_close_q);
          end
          2'd1: begin
            alu_a = AW'(last_close_q);
            alu_b = AW'(bar_q.bar_high);
          end
          2'd2: begin
            alu_a = AW'(bar_q.bar_low);
            alu_b = AW'(last_close_q);
          end
          default: begin
            alu_a = AW'(last_close_q);
            alu_b = AW'(bar_q.bar_low);
          end
        endcase
      end
      atr_pkg::ST_CMP: begin
        alu_op = atr_pkg::ALU_SUB;
        alu_a  = AW'(tr_q);
        alu_b  = AW'(cand_q);
      end
      atr_pkg::ST_ACC: begin
        alu_a = AW'(sum_q);
        alu_b = AW'(tr_q);
      end
      atr_pkg::ST_MUL: begin
        alu_a = AW'(work_q);
        alu_b = AW'(mcand_q);
      end
      atr_pkg::ST_MADD: begin
        alu_a = AW'(work_q);
        alu_b = AW'(tr_q);
      end
      atr_pkg::ST_DIV: begin
        alu_op = atr_pkg::ALU_SUB;
        alu_a  = AW'(rem_shift);
        alu_b  = AW'(period_q);
      end
      default: begin
        alu_op = atr_pkg::ALU_ADD;
      end
    endcase
  end

  atr_alu u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  assign status.accept   = accept;
  assign status.no_tr    = (bar_index_q == '0);
  assign status.borrow   = alu_carry;
  assign status.mode     = mode;
  assign status.out_free = out_free;

  atr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // period register and series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= PB'(atr_pkg::PERIOD_RESET);
      last_close_q <= '0;
      smoothed_q   <= '0;
      sum_q        <= '0;
      bar_index_q  <= '0;
      invalid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (accept && in_data_i.series_start) begin
        // new series: this bar becomes index zero
        last_close_q <= '0;
        smoothed_q   <= '0;
        sum_q        <= '0;
        bar_index_q  <= '0;
        invalid_q    <= 1'b0;
      end
      if ((ctrl.state == atr_pkg::ST_RNG) && alu_carry) begin
        invalid_q <= 1'b1;
      end
      if ((ctrl.state == atr_pkg::ST_ACC) &&
          ((mode == atr_pkg::MODE_ACCUM) || (mode == atr_pkg::MODE_SEED))) begin
        sum_q <= alu_res[SW-1:0];
      end
      if (out_load) begin
        if (ready) begin
          smoothed_q <= work_q[PW-1:0];
        end
        last_close_q <= bar_q.bar_close;
        bar_index_q  <= index_next;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bar_q    <= in_data_i;
      period_q <= p_eff;
    end
    unique case (ctrl.state)
      atr_pkg::ST_RNG: begin
        // the first bar of a series has no true range
        tr_q <= (!status.no_tr && !alu_carry) ? alu_res[PW-1:0] : '0;
      end
      atr_pkg::ST_CAND: begin
        if (!alu_carry) begin
          cand_q <= alu_res[PW-1:0];
        end
      end
      atr_pkg::ST_CMP: begin
        if (alu_carry) begin
          tr_q <= cand_q;
        end
      end
      atr_pkg::ST_ACC: begin
        rem_q <= '0;
        if (mode == atr_pkg::MODE_SEED) begin
          work_q <= alu_res[SW-1:0];
        end else begin
          // wilder: previous average times period minus one
          work_q  <= '0;
          mcand_q <= SW'(smoothed_q);
          mult_q  <= period_q - PB'(1);
        end
      end
      atr_pkg::ST_MUL: begin
        if (mult_q[0]) begin
          work_q <= alu_res[SW-1:0];
        end
        mcand_q <= mcand_q << 1;
        mult_q  <= mult_q >> 1;
      end
      atr_pkg::ST_MADD: begin
        work_q <= alu_res[SW-1:0];
        rem_q  <= '0;
      end
      atr_pkg::ST_DIV: begin
        rem_q  <= alu_carry ? rem_shift[PB-1:0] : alu_res[PB-1:0];
        work_q <= {work_q[SW-2:0], ~alu_carry};
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.range_average  <= avg;
      out_q.average_ready  <= ready;
      out_q.series_invalid <= invalid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a nonzero average only leaves for a ready, valid series
  `ATR_ASSERT_IMP(a_avg_gated, out_valid_q && (out_q.range_average != '0), out_q.average_ready && !out_q.series_invalid, "average without ready series")
  // the divider remainder stays below the period
  `ATR_ASSERT_IMP(a_rem_bound, ctrl.state == atr_pkg::ST_DIV, rem_q < period_q, "divider remainder out of range")
  // finishing a bar always leaves a word in the output register
  `ATR_ASSERT_NXT(a_out_load, out_load, out_valid_q, "finished bar not presented")

endmodule

/* test/average_true_range_filter_unit_test.sv */
// self-checking testbench for average_true_range_filter_unit: price bars in, smoothed ranges out
// depends on atr_pkg and the rtl top level; a local wilder model predicts the result word of each untyped bar
module average_true_range_filter_unit_test;

  localparam int unsigned PERIOD_BITS    = atr_pkg::PERIOD_BITS;
  localparam int unsigned PRICE_BITS     = atr_pkg::PRICE_BITS;
  localparam int unsigned SUM_BITS       = atr_pkg::SUM_BITS;
  localparam int unsigned INDEX_BITS     = atr_pkg::INDEX_BITS;
  localparam int unsigned RANDOM_BARS    = 1600;
  localparam int unsigned QUIET_TAIL     = 200;   // last bars run with no idling
  localparam int unsigned LONG_HOLD      = 300;   // receiver hold-off that backs up the input
  localparam int unsigned HOLD_AT_BAR    = 400;
  localparam int unsigned DRAIN_GAP      = 4;
  localparam int unsigned TAIL_CYCLES    = 80;    // a bit over the worst smoothing latency
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned REPORT_MAX     = 20;
  localparam logic [31:0] PRICE_ONE      = 32'h0001_0000;
  localparam logic [31:0] PRICE_TOP      = 32'hFFFF_FFFF;
  localparam logic [31:0] WALK_SPAN      = 32'h0004_0000;

  typedef struct {
    bit                     set_period;
    logic [PERIOD_BITS-1:0] period;
    atr_pkg::bar_t          word;
    bit                     typed;
    atr_pkg::atr_result_t   res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  atr_pkg::bar_t          in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  atr_pkg::atr_result_t   out_data_o;
  logic                   cfg_we_i;
  logic [PERIOD_BITS-1:0] cfg_wdata_i;

  // typed-in expectation that travels with the bar on the input channel
  logic                 drv_typed;
  atr_pkg::atr_result_t drv_typed_res;

  // local copy of the filter state
  logic [PERIOD_BITS-1:0] atr_period;
  logic [PRICE_BITS-1:0]  prev_close;
  logic [PRICE_BITS-1:0]  smoothed_tr;
  logic [SUM_BITS-1:0]    tr_sum;
  logic [INDEX_BITS-1:0]  bar_count;
  logic                   bad_bar_seen;

  atr_pkg::atr_result_t pending_atr[$];
  atr_pkg::atr_result_t predicted_atr;
  stim_row_t            stim_rows[$];

  bit          idle_on = 1'b1;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned mismatches = 0;
  int unsigned bars_accepted = 0;
  int unsigned periods_written = 0;
  int unsigned ready_results = 0;
  int unsigned invalid_results = 0;
  int unsigned quiet_cycles = 0;

  average_true_range_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // one wilder step: true range, seed sum or smoothing, sticky invalid flag
  function automatic atr_pkg::atr_result_t wilder_atr_next(input atr_pkg::bar_t word);
    logic [63:0] per, idx, tr, span, up_gap, dn_gap;
    logic [63:0] hi, lo;
    logic        ready;
    atr_pkg::atr_result_t res;
    hi  = 64'(word.bar_high);
    lo  = 64'(word.bar_low);
    per = 64'(atr_period);
    tr  = '0;
    if (word.series_start) begin
      prev_close   = '0;
      smoothed_tr  = '0;
      tr_sum       = '0;
      bar_count    = '0;
      bad_bar_seen = 1'b0;
    end
    if (hi < lo) bad_bar_seen = 1'b1;
    idx = 64'(bar_count);
    // first bar of a series has no previous close, so no range
    if (idx != 0) begin
      span   = (hi >= lo) ? hi - lo : 64'd0;
      up_gap = (hi >= 64'(prev_close)) ? hi - 64'(prev_close) : 64'(prev_close) - hi;
      dn_gap = (lo >= 64'(prev_close)) ? lo - 64'(prev_close) : 64'(prev_close) - lo;
      tr = span;
      if (up_gap > tr) tr = up_gap;
      if (dn_gap > tr) tr = dn_gap;
    end
    ready = (per != 0) && (idx >= per);
    if (per != 0) begin
      if (idx >= 1 && idx <= per) tr_sum = tr_sum + tr[SUM_BITS-1:0];
      if (idx == per) smoothed_tr = PRICE_BITS'(64'(tr_sum) / per);
      else if (idx > per) smoothed_tr = PRICE_BITS'((64'(smoothed_tr) * (per - 1) + tr) / per);
    end
    res.range_average  = (ready && !bad_bar_seen) ? smoothed_tr : '0;
    res.average_ready  = ready;
    res.series_invalid = bad_bar_seen;
    prev_close = word.bar_close;
    bar_count  = (idx < per + 1) ? INDEX_BITS'(idx + 1) : INDEX_BITS'(per + 1);
    return res;
  endfunction

  function automatic void add_row(input int set_p, input int unsigned per,
                                  input logic [31:0] hi, input logic [31:0] lo,
                                  input logic [31:0] cl, input int start, input int typed,
                                  input logic [31:0] avg, input int rdy, input int inv);
    stim_row_t row;
    row.set_period             = (set_p != 0);
    row.period                 = PERIOD_BITS'(per);
    row.word.bar_high          = hi;
    row.word.bar_low           = lo;
    row.word.bar_close         = cl;
    row.word.series_start      = (start != 0);
    row.typed                  = (typed != 0);
    row.res.range_average      = avg;
    row.res.average_ready      = (rdy != 0);
    row.res.series_invalid     = (inv != 0);
    stim_rows.push_back(row);
  endfunction

  // offer one bar, with an occasional gap in front, and wait for it to be taken
  task automatic send_bar(input atr_pkg::bar_t word, input bit typed,
                          input atr_pkg::atr_result_t typed_res);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_data_i     <= word;
    drv_typed     <= typed;
    drv_typed_res <= typed_res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // period writes happen only with the block drained
  task automatic write_period(input logic [PERIOD_BITS-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_atr.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // predictor runs on every accepted bar and on every period write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atr_period   = PERIOD_BITS'(atr_pkg::PERIOD_RESET);
      prev_close   = '0;
      smoothed_tr  = '0;
      tr_sum       = '0;
      bar_count    = '0;
      bad_bar_seen = 1'b0;
      pending_atr.delete();
    end else begin
      if (cfg_we_i) begin
        atr_period = cfg_wdata_i;
        periods_written++;
      end
      if (in_valid_i && !in_stall_o) begin
        predicted_atr = wilder_atr_next(in_data_i);
        pending_atr.push_back(drv_typed ? drv_typed_res : predicted_atr);
        bars_accepted++;
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_atr.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result word with nothing expected: avg %h ready %b invalid %b",
                   $time, out_data_o.range_average, out_data_o.average_ready,
                   out_data_o.series_invalid);
      end else begin
        if (out_data_o.range_average  !== pending_atr[0].range_average ||
            out_data_o.average_ready  !== pending_atr[0].average_ready ||
            out_data_o.series_invalid !== pending_atr[0].series_invalid) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch, expected avg %h ready %b invalid %b, got avg %h ready %b invalid %b",
                     $time, pending_atr[0].range_average, pending_atr[0].average_ready,
                     pending_atr[0].series_invalid, out_data_o.range_average,
                     out_data_o.average_ready, out_data_o.series_invalid);
        end
        void'(pending_atr.pop_front());
      end
      if (out_data_o.average_ready) ready_results++;
      if (out_data_o.series_invalid) invalid_results++;
    end
  end

  // receiver stalls in bursts, plus one long hold-off to back the block up
  initial begin
    int unsigned run_len;
    logic        stall_val;
    out_stall_i <= 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        stall_val = 1'b1;
        run_len   = LONG_HOLD;
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_val = 1'b1;
        run_len   = $urandom_range(1, 16);
      end else begin
        stall_val = 1'b0;
        run_len   = $urandom_range(1, 24);
      end
      out_stall_i <= stall_val;
      repeat (run_len) @(posedge clk_i);
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("average_true_range_filter_unit_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_bars;
    int unsigned series_len;
    int unsigned sel;
    logic [PERIOD_BITS-1:0] per;
    bit          new_series;
    longint      walk_close, center, hi, lo, cl, swap_tmp;
    atr_pkg::bar_t        word;
    atr_pkg::atr_result_t no_res;

    no_res        = '0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    drv_typed     <= 1'b0;
    drv_typed_res <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: reset period first, then extremes of period and price
    // first bar after reset, no series start, default period of 14
    add_row(0, 0, 32'h0005_0000, 32'h0003_0000, 32'h0004_0000, 0, 1, 0, 0, 0);
    add_row(0, 0, PRICE_TOP, 0, PRICE_TOP, 0, 1, 0, 0, 0);
    // period 1: range of the second bar is the average at once
    add_row(1, 1, 0, 0, 0, 1, 1, 0, 0, 0);
    add_row(0, 0, PRICE_TOP, PRICE_TOP, 0, 0, 1, PRICE_TOP, 1, 0);
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
    // high below low: flag sticks, average reads zero
    add_row(0, 0, PRICE_ONE, 2 * PRICE_ONE, 32'h0001_8000, 0, 1, 0, 1, 1);
    add_row(0, 0, 3 * PRICE_ONE, PRICE_ONE, 2 * PRICE_ONE, 0, 1, 0, 1, 1);
    add_row(0, 0, 3 * PRICE_ONE, PRICE_ONE, 2 * PRICE_ONE, 1, 1, 0, 0, 0);
    // period zero disables the average but still tracks invalid bars
    add_row(1, 0, PRICE_TOP, 0, PRICE_ONE, 0, 1, 0, 0, 0);
    add_row(0, 0, 0, PRICE_TOP, 0, 0, 1, 0, 0, 1);
    // largest period
    add_row(1, 1023, 5 * PRICE_ONE, 3 * PRICE_ONE, 4 * PRICE_ONE, 1, 1, 0, 0, 0);
    add_row(0, 0, PRICE_TOP, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
    // period 2: seed, then smoothing, including a gap down
    add_row(1, 2, 5 * PRICE_ONE, 3 * PRICE_ONE, 4 * PRICE_ONE, 1, 1, 0, 0, 0);
    add_row(0, 0, 6 * PRICE_ONE, 4 * PRICE_ONE, 5 * PRICE_ONE, 0, 0, 0, 0, 0);
    add_row(0, 0, 8 * PRICE_ONE, 7 * PRICE_ONE, 7 * PRICE_ONE, 0, 0, 0, 0, 0);
    add_row(0, 0, 5 * PRICE_ONE, 4 * PRICE_ONE, 4 * PRICE_ONE, 0, 0, 0, 0, 0);
    // longer period mid-series: seeding resumes toward it
    add_row(1, 5, 6 * PRICE_ONE, 4 * PRICE_ONE, 5 * PRICE_ONE, 0, 0, 0, 0, 0);
    add_row(0, 0, 9 * PRICE_ONE, 5 * PRICE_ONE, 8 * PRICE_ONE, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h0008_8000, 32'h0007_1234, 32'h0007_ffff, 0, 0, 0, 0, 0);
    // shorter period mid-series: smoothing from the current value
    add_row(1, 1, 32'h000a_0001, 32'h0003_0003, 32'h0006_0000, 0, 0, 0, 0, 0);
    add_row(0, 0, PRICE_TOP, PRICE_TOP, PRICE_TOP, 0, 0, 0, 0, 0);
    // series start with a bad bar: flag cleared then set again
    add_row(0, 0, 0, 0, PRICE_TOP, 1, 1, 0, 0, 0);
    add_row(0, 0, 0, PRICE_ONE, 0, 1, 1, 0, 0, 1);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].set_period) write_period(stim_rows[i].period);
      send_bar(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].res);
    end

    // random part: phases of one period each, mostly short periods and
    // well-formed random-walk bars, with some noise and rare bad bars
    random_bars = 0;
    walk_close  = 64'h0064_0000;
    while (random_bars < RANDOM_BARS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0)      per = '0;
      else if (sel == 1) per = PERIOD_BITS'(1023);
      else if (sel == 2) per = PERIOD_BITS'($urandom_range(100, 1023));
      else               per = PERIOD_BITS'($urandom_range(1, 16));
      write_period(per);
      if (per > 300)     series_len = $urandom_range(50, 150);
      else if (per > 16) series_len = per + $urandom_range(5, 40);
      else               series_len = $urandom_range(10, 60);
      new_series = ($urandom_range(0, 3) != 0);
      for (int unsigned k = 0; k < series_len; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          hi = longint'($urandom);
          lo = longint'($urandom);
          cl = longint'($urandom);
        end else if (sel < 9) begin
          hi = $urandom_range(0, 1) ? longint'(PRICE_TOP) : 0;
          lo = $urandom_range(0, 1) ? longint'(PRICE_TOP) : 0;
          cl = $urandom_range(0, 1) ? longint'(PRICE_TOP) : 0;
        end else begin
          center = walk_close + longint'($urandom_range(0, 2 * WALK_SPAN)) - longint'(WALK_SPAN);
          if (center < 0) center = 0;
          if (center > longint'(PRICE_TOP)) center = longint'(PRICE_TOP);
          hi = center + longint'($urandom_range(0, WALK_SPAN));
          if (hi > longint'(PRICE_TOP)) hi = longint'(PRICE_TOP);
          lo = center - longint'($urandom_range(0, WALK_SPAN));
          if (lo < 0) lo = 0;
          cl = lo + longint'($urandom_range(0, 32'(hi - lo)));
        end
        if (hi < lo) begin
          swap_tmp = hi;
          hi       = lo;
          lo       = swap_tmp;
        end
        // rare bar with high below low
        if ($urandom_range(0, 249) == 0 && hi != lo) begin
          swap_tmp = hi;
          hi       = lo;
          lo       = swap_tmp;
        end
        walk_close        = cl;
        word.bar_high     = 32'(hi);
        word.bar_low      = 32'(lo);
        word.bar_close    = 32'(cl);
        word.series_start = (k == 0 && new_series) || ($urandom_range(0, 99) == 0);
        send_bar(word, 1'b0, no_res);
        random_bars++;
        if (random_bars == HOLD_AT_BAR) hold_request = 1'b1;
        if (random_bars >= RANDOM_BARS - QUIET_TAIL) idle_on = 1'b0;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_atr.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_atr.size() != 0) mismatches++;

    $display("bars %0d, period writes %0d, results with average ready %0d, flagged invalid %0d",
             bars_accepted, periods_written, ready_results, invalid_results);
    $display("mismatches %0d", mismatches);
    if (mismatches == 0) begin
      $display("average_true_range_filter_unit_test OK");
    end else begin
      $display("average_true_range_filter_unit_test NOT OK");
    end
    $finish;
  end

endmodule
